// ----- hdl/u2h_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 to UCS-2 hex encoder.
`default_nettype none

package u2h_pkg;

  localparam int unsigned CodeW  = 16;
  localparam int unsigned CountW = 3;
  localparam int unsigned HexW   = 7;

  localparam logic [7:0]  ByteMask   = 8'hFF;
  localparam logic [5:0]  ContMask   = 6'h3F;
  localparam logic [1:0]  ContPrefix = 2'b10;
  localparam logic [7:0]  AsciiLimit = 8'd128;
  localparam logic [3:0]  DecLimit   = 4'd10;
  localparam logic [6:0]  AsciiZero  = 7'h30;
  localparam logic [6:0]  AsciiAlpha = 7'h37;

  typedef struct packed {
    logic             vld;
    logic [CodeW-1:0] code;
  } code_beat_t;

  typedef struct packed {
    logic [1:0] fill;
    logic [1:0] digit;
  } ser_status_t;

  function automatic logic [CountW-1:0] lead_len(input logic [7:0] b);
    logic [CountW-1:0] n;
    n = 3'd1;
    if (b < AsciiLimit || b == ByteMask) begin
      n = 3'd1;
    end else if (b[6] == 1'b0) begin
      n = 3'd1;
    end else if (b[5] == 1'b0) begin
      n = 3'd2;
    end else if (b[4] == 1'b0) begin
      n = 3'd3;
    end else if (b[3] == 1'b0) begin
      n = 3'd4;
    end else if (b[2] == 1'b0) begin
      n = 3'd5;
    end else if (b[1] == 1'b0) begin
      n = 3'd6;
    end else begin
      n = 3'd7;
    end
    return n;
  endfunction

  function automatic logic [HexW-1:0] hex_ascii(input logic [3:0] d);
    logic [HexW-1:0] c;
    if (d < DecLimit) begin
      c = AsciiZero + {3'b000, d};
    end else begin
      c = AsciiAlpha + {3'b000, d};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/u2h_decode.sv -----
// Byte decoder: sequence state, code accumulation and completed-code beats.
`default_nettype none

module u2h_decode
  import u2h_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_string_i,
  output code_beat_t      beat_o
);

  logic [CountW-1:0] bytes_left_q, bytes_left_d;
  logic [CodeW-1:0]  code_accum_q, code_accum_d;
  logic              high_seen_q, high_seen_d;
  logic              bad_seq_q, bad_seq_d;
  logic              emit;
  logic [CodeW-1:0]  code;
  logic [CountW-1:0] n;
  logic [7:0]        payload;
  logic [5:0]        cont;

  always_comb begin
    bytes_left_d = bytes_left_q;
    code_accum_d = code_accum_q;
    high_seen_d  = high_seen_q;
    bad_seq_d    = bad_seq_q;
    emit         = 1'b0;
    code         = code_accum_q;
    n            = lead_len(in_byte_i);
    payload      = in_byte_i & (ByteMask >> ({1'b0, n} + 4'd1));
    cont         = in_byte_i[5:0] & ContMask;
    if (bytes_left_q == '0) begin
      if (n == 3'd1) begin
        emit = (in_byte_i != 8'h00);
        code = {8'h00, in_byte_i};
      end else begin
        if (n == 3'd2) begin
          code_accum_d = {5'b00000, payload[4:0], 6'b000000};
        end else if (n == 3'd3) begin
          code_accum_d = {payload[3:0], 12'h000};
        end else begin
          code_accum_d = '0;
        end
        high_seen_d  = (n >= 3'd4) && (payload != 8'h00);
        bad_seq_d    = 1'b0;
        bytes_left_d = n - 3'd1;
      end
    end else begin
      if (in_byte_i[7:6] != ContPrefix) begin
        bad_seq_d = 1'b1;
      end else begin
        case (bytes_left_q)
          3'd1: code_accum_d = code_accum_q | {10'h000, cont};
          3'd2: code_accum_d = code_accum_q | {4'h0, cont, 6'b000000};
          3'd3: begin
            code_accum_d = code_accum_q | {cont[3:0], 12'h000};
            high_seen_d  = high_seen_q | (cont[5:4] != 2'b00);
          end
          default: high_seen_d = high_seen_q | (cont != 6'h00);
        endcase
      end
      bytes_left_d = bytes_left_q - 3'd1;
      if (bytes_left_d == '0) begin
        emit         = !bad_seq_d && ((code_accum_d != '0) || high_seen_d);
        code         = code_accum_d;
        code_accum_d = '0;
        high_seen_d  = 1'b0;
        bad_seq_d    = 1'b0;
      end
    end
    if (end_of_string_i) begin
      bytes_left_d = '0;
      code_accum_d = '0;
      high_seen_d  = 1'b0;
      bad_seq_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      code_accum_q <= '0;
      high_seen_q  <= 1'b0;
      bad_seq_q    <= 1'b0;
    end else if (accept_i) begin
      bytes_left_q <= bytes_left_d;
      code_accum_q <= code_accum_d;
      high_seen_q  <= high_seen_d;
      bad_seq_q    <= bad_seq_d;
    end
  end

  assign beat_o.vld  = accept_i && emit;
  assign beat_o.code = code;

endmodule

`default_nettype wire

// ----- hdl/u2h_serial.sv -----
// Two-entry code buffer and hex digit serialiser with registered output.
`default_nettype none

module u2h_serial
  import u2h_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire code_beat_t      beat_i,
  output logic                 space_o,
  output ser_status_t          status_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [HexW-1:0]      hex_char_o,
  output logic                 last_of_run_o
);

  logic [CodeW-1:0] code_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q, fill_d;
  logic [1:0]       digit_q;
  logic             out_valid_q;
  logic [HexW-1:0]  hex_q;
  logic             last_q;
  logic             load, pop;
  logic [CodeW-1:0] head;
  logic [3:0]       nibble;

  assign head = code_q[rd_ptr_q];
  assign load = (fill_q != 2'd0) && (!out_valid_q || out_ready_i);
  assign pop  = load && (digit_q == 2'd3);

  always_comb begin
    case (digit_q)
      2'd0:    nibble = head[15:12];
      2'd1:    nibble = head[11:8];
      2'd2:    nibble = head[7:4];
      default: nibble = head[3:0];
    endcase
    fill_d = fill_q + {1'b0, beat_i.vld} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (beat_i.vld) begin
      code_q[wr_ptr_q] <= beat_i.code;
    end
    if (load) begin
      hex_q  <= hex_ascii(nibble);
      last_q <= (digit_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= 1'b0;
      rd_ptr_q    <= 1'b0;
      fill_q      <= 2'd0;
      digit_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (beat_i.vld) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (load) begin
        digit_q     <= digit_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign space_o         = (fill_q != 2'd2);
  assign status_o.fill   = fill_q;
  assign status_o.digit  = digit_q;
  assign out_valid_o     = out_valid_q;
  assign hex_char_o      = hex_q;
  assign last_of_run_o   = last_q;

endmodule

`default_nettype wire

// ----- hdl/utf8_to_ucs2_hex.sv -----
// Top level of the UTF-8 to UCS-2 hex encoder.
//
// Input channel: one UTF-8 byte per beat (in_byte_i, end_of_string_i) under
// in_valid_i / in_ready_o. Output channel: one ASCII hex digit per beat
// (hex_char_o, last_of_run_o) under out_valid_o / out_ready_i.
// Each completed character of nonzero code yields four digits, most
// significant nibble first, the fourth flagged by last_of_run_o.
// The completing beat writes a code into the buffer, and its first digit is
// then loaded into the output register. A byte is decoded in the cycle it is
// accepted, so a byte can be taken every cycle while the buffer has space; a
// code drains at one digit per cycle while the receiver is ready, so for
// single-byte characters the output digit rate bounds the input byte rate.
// A two-entry code buffer sits between decoder and serialiser; in_ready_o
// drops only while both entries are occupied.
// A stalled receiver holds the current digit; the buffer fills and then
// back-pressures the input. Reset clears the sequence state, the buffer
// and the output valid flag; no clearing pass is needed.
`default_nettype none

module utf8_to_ucs2_hex
  import u2h_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            end_of_string_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [HexW-1:0]      hex_char_o,
  output logic                 last_of_run_o
);

  logic        accept;
  code_beat_t  beat;
  ser_status_t status;

  assign accept = in_valid_i && in_ready_o;

  u2h_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .beat_o          (beat)
  );

  u2h_serial u_serial (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_i        (beat),
    .space_o       (in_ready_o),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hex_char_o    (hex_char_o),
    .last_of_run_o (last_of_run_o)
  );

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fill != 2'd3)
    else $error("code buffer overfilled");

  a_hex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((hex_char_o >= 7'h30 && hex_char_o <= 7'h39) ||
                     (hex_char_o >= 7'h41 && hex_char_o <= 7'h46)))
    else $error("digit outside hex alphabet");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.fill == 2'd0 && !beat.vld) |=> !$rose(out_valid_o))
    else $error("output beat without buffered code");

  a_last_on_fourth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o) |-> (status.digit == 2'd0))
    else $error("last digit flagged out of step");

endmodule

`default_nettype wire

// ----- verif/utf8_to_ucs2_hex_tb.sv -----
// Self-checking testbench for the UTF-8 to UCS-2 hex encoder.
module utf8_to_ucs2_hex_tb;
  import u2h_pkg::*;

  localparam logic [HexW-1:0] CharZero = 7'h30;
  localparam logic [HexW-1:0] CharTen  = 7'h41;
  localparam int TotalBeats = 470;
  localparam int MidPause   = 250;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } byte_beat_t;

  class hex_scoreboard;
    logic [HexW:0]     digits_due[$];
    int                errors = 0;
    logic [CountW-1:0] cont_left = '0;
    logic [CodeW-1:0]  code_acc = '0;
    logic              high_seen = 1'b0;
    logic              bad_cont = 1'b0;

    function void clear_seq();
      cont_left = '0;
      code_acc  = '0;
      high_seen = 1'b0;
      bad_cont  = 1'b0;
    endfunction

    function int unsigned run_length(logic [7:0] b);
      int unsigned n;
      n = 0;
      if (b < AsciiLimit || b == ByteMask) begin
        return 1;
      end
      while (n < 8 && b[7 - n]) begin
        n++;
      end
      return (n < 2) ? 1 : n;
    endfunction

    function void merge(logic [63:0] part);
      code_acc = code_acc | part[CodeW-1:0];
      if (part[63:CodeW] != '0) begin
        high_seen = 1'b1;
      end
    endfunction

    function void push_code(logic [CodeW-1:0] c);
      logic [3:0]      d;
      logic [HexW-1:0] ch;
      for (int k = 0; k < 4; k++) begin
        d  = c[15 - 4 * k -: 4];
        ch = (d < 4'd10) ? CharZero + {3'b000, d} : CharTen + {3'b000, d} - 7'd10;
        digits_due.push_back({ch, k == 3});
      end
    endfunction

    function void note_byte(logic [7:0] b, logic eos);
      logic [63:0] part;
      int unsigned n;
      int unsigned sh;
      if (cont_left == 0) begin
        n = run_length(b);
        if (n == 1) begin
          if (b != 8'h00) begin
            push_code({8'h00, b});
          end
        end else begin
          clear_seq();
          part = {56'd0, b & (ByteMask >> (n + 1))};
          merge(part << (6 * (n - 1)));
          cont_left = CountW'(n - 1);
        end
      end else begin
        sh = 6 * (cont_left - 1);
        if (b[7:6] != ContPrefix) begin
          bad_cont = 1'b1;
        end else begin
          part = {58'd0, b[5:0]};
          merge(part << sh);
        end
        cont_left = cont_left - 3'd1;
        if (cont_left == 0) begin
          if (!bad_cont && (code_acc != '0 || high_seen)) begin
            push_code(code_acc);
          end
          clear_seq();
        end
      end
      if (eos) begin
        clear_seq();
      end
    endfunction

    function void check_digit(logic [HexW-1:0] ch, logic last);
      logic [HexW:0] want;
      if (digits_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected digit, expected none, actual %h last %b", $time, ch, last);
      end else begin
        want = digits_due.pop_front();
        if (want[HexW:1] != ch) begin
          errors++;
          $display("%0t: hex_char expected %h actual %h", $time, want[HexW:1], ch);
        end
        if (want[0] != last) begin
          errors++;
          $display("%0t: last_of_run expected %b actual %b", $time, want[0], last);
        end
      end
    endfunction

    function int pending();
      return digits_due.size();
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [7:0]      in_byte_i = 8'h00;
  logic            end_of_string_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [HexW-1:0] hex_char_o;
  logic            last_of_run_o;

  hex_scoreboard sb = new;
  byte_beat_t    beats[$];
  int            burst_left = 0;
  int            sent = 0;

  utf8_to_ucs2_hex dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hex_char_o      (hex_char_o),
    .last_of_run_o   (last_of_run_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_byte(in_byte_i, end_of_string_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_digit(hex_char_o, last_of_run_o);
      end
    end
  end

  function void add_beat(logic [7:0] b, logic eos);
    beats.push_back({b, eos});
  endfunction

  task automatic offer(byte_beat_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    in_byte_i       <= it.b;
    end_of_string_i <= it.eos;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic send_queued();
    while (beats.size() != 0) begin
      offer(beats.pop_front());
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic make_group();
    logic [7:0] seq[7];
    int         kind;
    int         n;
    int         r;
    int         pos;
    int         cut;
    logic       zero_fill;
    logic       tail_eos;
    kind     = $urandom_range(0, 99);
    tail_eos = ($urandom_range(0, 19) == 0);
    if (kind < 30) begin
      seq[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 127));
      add_beat(seq[0], tail_eos);
    end else if (kind < 92) begin
      r = $urandom_range(0, 9);
      n = (r < 4) ? 2 : (r < 7) ? 3 : (r == 7) ? 4 : (r == 8) ? $urandom_range(5, 6) : 7;
      zero_fill = ($urandom_range(0, 9) == 0);
      seq[0] = (ByteMask << (8 - n)) |
               (zero_fill ? 8'h00 : (8'($urandom) & (ByteMask >> (n + 1))));
      for (int i = 1; i < n; i++) begin
        seq[i] = 8'h80 | (zero_fill ? 8'h00 : (8'($urandom) & 8'h3F));
      end
      if (kind < 80) begin
        for (int i = 0; i < n; i++) begin
          add_beat(seq[i], tail_eos && i == n - 1);
        end
      end else if ($urandom_range(0, 1) == 0) begin
        pos = $urandom_range(1, n - 1);
        seq[pos] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127))
                                               : 8'($urandom_range(192, 255));
        for (int i = 0; i < n; i++) begin
          add_beat(seq[i], tail_eos && i == n - 1);
        end
      end else begin
        cut = $urandom_range(1, n - 1);
        for (int i = 0; i < cut; i++) begin
          add_beat(seq[i], i == cut - 1);
        end
      end
    end else begin
      add_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin : receiver
    int mode;
    int span;
    int phase;
    phase = 0;
    repeat (11) @(posedge clk_i);
    out_ready_i <= 1'b1;
    repeat (300) @(posedge clk_i);
    out_ready_i <= 1'b0;
    repeat (120) @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 9);
      span = $urandom_range(20, 150);
      if (mode < 3) begin
        out_ready_i <= 1'b1;
        repeat (span) @(posedge clk_i);
      end else if (mode < 6) begin
        repeat (span) begin
          out_ready_i <= 1'($urandom_range(0, 1));
          @(posedge clk_i);
        end
      end else if (mode < 9) begin
        repeat (span) begin
          out_ready_i <= (phase % 3 != 0);
          phase++;
          @(posedge clk_i);
        end
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(40, 90)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic mid_done;
    mid_done = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_beat(8'h00, 1'b0);
    add_beat(8'h7F, 1'b0);
    add_beat(8'h80, 1'b0);
    add_beat(8'hFF, 1'b1);
    add_beat(8'hC3, 1'b0);
    add_beat(8'hA9, 1'b0);
    add_beat(8'hC0, 1'b0);
    add_beat(8'h80, 1'b0);
    add_beat(8'hE2, 1'b0);
    add_beat(8'h82, 1'b0);
    add_beat(8'hAC, 1'b0);
    add_beat(8'hF0, 1'b0);
    add_beat(8'h9F, 1'b0);
    add_beat(8'h98, 1'b0);
    add_beat(8'h80, 1'b0);
    add_beat(8'hC3, 1'b0);
    add_beat(8'h41, 1'b0);
    add_beat(8'hE2, 1'b0);
    add_beat(8'h82, 1'b1);
    add_beat(8'hFE, 1'b0);
    for (int i = 0; i < 5; i++) begin
      add_beat(8'h80, 1'b0);
    end
    add_beat(8'h81, 1'b1);
    send_queued();
    drain();

    while (sent < TotalBeats) begin
      make_group();
      send_queued();
      if (!mid_done && sent >= MidPause) begin
        mid_done = 1'b1;
        drain();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #(8 * 200000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
